@@ rtl/cfd_pkg.sv @@
`timescale 1ns / 1ps

package cfd_pkg;

	// Cell type codes
	localparam logic [3:0] KIND_BAR     = 4'd1;
	localparam logic [3:0] KIND_TRI     = 4'd2;
	localparam logic [3:0] KIND_QUAD    = 4'd3;
	localparam logic [3:0] KIND_TET     = 4'd4;
	localparam logic [3:0] KIND_PYRAMID = 4'd5;
	localparam logic [3:0] KIND_PRISM   = 4'd6;
	localparam logic [3:0] KIND_HEX     = 4'd7;
	localparam logic [3:0] KIND_POINT   = 4'd10;

	// Input beat: one mesh cell
	typedef struct packed {
		logic [3:0]  cell_kind;
		logic [31:0] corner_0;
		logic [31:0] corner_1;
		logic [31:0] corner_2;
		logic [31:0] corner_3;
		logic [31:0] corner_4;
		logic [31:0] corner_5;
		logic [31:0] corner_6;
		logic [31:0] corner_7;
		logic        mesh_start;
	} cell_t;

	// Output beat: one face
	typedef struct packed {
		logic [2:0]  face_size;
		logic [31:0] face_vertex_a;
		logic [31:0] face_vertex_b;
		logic [31:0] face_vertex_c;
		logic [31:0] face_vertex_d;
		logic [31:0] face_list_start;
		logic [31:0] face_serial;
		logic        last_face;
		logic        bad_kind;
	} face_t;

	// Per-type summary: face count, corner total, first row of the shape table
	typedef struct packed {
		logic       known;
		logic [2:0] faces;
		logic [4:0] corners;
		logic [4:0] first;
	} kind_info_t;

	// One face: corner count and the cell corners it uses
	typedef struct packed {
		logic [2:0] size;
		logic [2:0] c0;
		logic [2:0] c1;
		logic [2:0] c2;
		logic [2:0] c3;
	} shape_t;

	function automatic kind_info_t kind_info(logic [3:0] kind);
		kind_info_t r;
		unique case (kind)
			KIND_BAR:     r = '{1'b1, 3'd1, 5'd2,  5'd0};
			KIND_TRI:     r = '{1'b1, 3'd1, 5'd3,  5'd1};
			KIND_QUAD:    r = '{1'b1, 3'd1, 5'd4,  5'd2};
			KIND_TET:     r = '{1'b1, 3'd4, 5'd12, 5'd3};
			KIND_PYRAMID: r = '{1'b1, 3'd5, 5'd16, 5'd7};
			KIND_PRISM:   r = '{1'b1, 3'd5, 5'd18, 5'd12};
			KIND_HEX:     r = '{1'b1, 3'd6, 5'd24, 5'd17};
			KIND_POINT:   r = '{1'b1, 3'd1, 5'd1,  5'd23};
			default:      r = '{1'b0, 3'd1, 5'd0,  5'd0};
		endcase
		return r;
	endfunction

	function automatic shape_t face_shape(logic [4:0] row);
		shape_t s;
		unique case (row)
			5'd0:    s = '{3'd2, 3'd0, 3'd1, 3'd0, 3'd0};
			5'd1:    s = '{3'd3, 3'd0, 3'd1, 3'd2, 3'd0};
			5'd2:    s = '{3'd4, 3'd0, 3'd1, 3'd2, 3'd3};
			// tetrahedron
			5'd3:    s = '{3'd3, 3'd0, 3'd3, 3'd1, 3'd0};
			5'd4:    s = '{3'd3, 3'd1, 3'd3, 3'd2, 3'd0};
			5'd5:    s = '{3'd3, 3'd2, 3'd3, 3'd0, 3'd0};
			5'd6:    s = '{3'd3, 3'd0, 3'd1, 3'd2, 3'd0};
			// pyramid, base last
			5'd7:    s = '{3'd3, 3'd0, 3'd4, 3'd1, 3'd0};
			5'd8:    s = '{3'd3, 3'd1, 3'd4, 3'd2, 3'd0};
			5'd9:    s = '{3'd3, 3'd2, 3'd4, 3'd3, 3'd0};
			5'd10:   s = '{3'd3, 3'd3, 3'd4, 3'd0, 3'd0};
			5'd11:   s = '{3'd4, 3'd0, 3'd1, 3'd2, 3'd3};
			// prism
			5'd12:   s = '{3'd3, 3'd0, 3'd1, 3'd2, 3'd0};
			5'd13:   s = '{3'd3, 3'd3, 3'd5, 3'd4, 3'd0};
			5'd14:   s = '{3'd4, 3'd5, 3'd2, 3'd1, 3'd4};
			5'd15:   s = '{3'd4, 3'd4, 3'd1, 3'd0, 3'd3};
			5'd16:   s = '{3'd4, 3'd0, 3'd2, 3'd5, 3'd3};
			// hexahedron
			5'd17:   s = '{3'd4, 3'd0, 3'd3, 3'd7, 3'd4};
			5'd18:   s = '{3'd4, 3'd7, 3'd3, 3'd2, 3'd6};
			5'd19:   s = '{3'd4, 3'd6, 3'd2, 3'd1, 3'd5};
			5'd20:   s = '{3'd4, 3'd5, 3'd1, 3'd0, 3'd4};
			5'd21:   s = '{3'd4, 3'd0, 3'd1, 3'd2, 3'd3};
			5'd22:   s = '{3'd4, 3'd4, 3'd7, 3'd6, 3'd5};
			// point
			5'd23:   s = '{3'd1, 3'd0, 3'd0, 3'd0, 3'd0};
			default: s = '{3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
		endcase
		return s;
	endfunction

endpackage

@@ rtl/cfd_front.sv @@
`timescale 1ns / 1ps

module cfd_front import cfd_pkg::*; #(
	parameter int IW = 32,
	parameter int CW = 32,
	parameter int EW = 1 + 3 + 5 + 2 * CW + 8 * IW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_t         mesh_cell,
	input  logic          cell_valid,
	output logic          cell_stall,
	input  logic          full,
	output logic          push,
	output logic [EW-1:0] entry
);

	typedef struct packed {
		logic                 bad;
		logic [2:0]           faces;
		logic [4:0]           first;
		logic [CW-1:0]        vtx;
		logic [CW-1:0]        ser;
		logic [7:0][IW-1:0]   corners;
	} entry_t;

	kind_info_t    info;
	entry_t        ent;
	logic [CW-1:0] vtx_q;
	logic [CW-1:0] ser_q;
	logic [CW-1:0] vtx_base;
	logic [CW-1:0] ser_base;

	assign cell_stall = full;
	assign push       = cell_valid && !full;

	// classify the cell and pick its starting counters
	always_comb begin
		info     = kind_info(mesh_cell.cell_kind);
		vtx_base = mesh_cell.mesh_start ? '0 : vtx_q;
		ser_base = mesh_cell.mesh_start ? '0 : ser_q;
		ent.bad        = !info.known;
		ent.faces      = info.faces;
		ent.first      = info.first;
		ent.vtx        = vtx_base;
		ent.ser        = ser_base;
		ent.corners[0] = mesh_cell.corner_0[IW-1:0];
		ent.corners[1] = mesh_cell.corner_1[IW-1:0];
		ent.corners[2] = mesh_cell.corner_2[IW-1:0];
		ent.corners[3] = mesh_cell.corner_3[IW-1:0];
		ent.corners[4] = mesh_cell.corner_4[IW-1:0];
		ent.corners[5] = mesh_cell.corner_5[IW-1:0];
		ent.corners[6] = mesh_cell.corner_6[IW-1:0];
		ent.corners[7] = mesh_cell.corner_7[IW-1:0];
	end

	assign entry = EW'(ent);

	// running counters; an unknown type leaves them at the base value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtx_q <= '0;
			ser_q <= '0;
		end else if (push) begin
			if (info.known) begin
				vtx_q <= vtx_base + CW'(info.corners);
				ser_q <= ser_base + CW'(info.faces);
			end else begin
				vtx_q <= vtx_base;
				ser_q <= ser_base;
			end
		end
	end

endmodule

@@ rtl/cfd_queue.sv @@
`timescale 1ns / 1ps

module cfd_queue #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = slot_q[rd_q];

	// two entry slots
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue read while empty");
`endif

endmodule

@@ rtl/cfd_back.sv @@
`timescale 1ns / 1ps

module cfd_back import cfd_pkg::*; #(
	parameter int IW = 32,
	parameter int CW = 32,
	parameter int EW = 1 + 3 + 5 + 2 * CW + 8 * IW
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [EW-1:0] entry,
	input  logic          empty,
	output logic          pop,
	output face_t         face,
	output logic          face_valid,
	input  logic          face_stall
);

	typedef struct packed {
		logic                 bad;
		logic [2:0]           faces;
		logic [4:0]           first;
		logic [CW-1:0]        vtx;
		logic [CW-1:0]        ser;
		logic [7:0][IW-1:0]   corners;
	} entry_t;

	entry_t        ent;
	shape_t        sh;
	face_t         nxt;
	face_t         face_q;
	logic          valid_q;
	logic [2:0]    k_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] ser_q;
	logic [CW-1:0] cur_pos;
	logic [CW-1:0] cur_ser;
	logic          advance;
	logic          take;
	logic          last;

	assign ent     = entry_t'(entry);
	assign advance = !valid_q || !face_stall;
	assign take    = advance && !empty;
	assign last    = ((k_q + 3'd1) == ent.faces);
	assign pop     = take && last;

	// build the face at index k of the head cell
	always_comb begin
		sh      = face_shape(ent.first + 5'(k_q));
		cur_pos = (k_q == 3'd0) ? ent.vtx : pos_q;
		cur_ser = (k_q == 3'd0) ? ent.ser : ser_q;
		nxt                 = '0;
		nxt.face_list_start = 32'(cur_pos);
		nxt.face_serial     = 32'(cur_ser);
		nxt.last_face       = last;
		nxt.bad_kind        = ent.bad;
		if (!ent.bad) begin
			nxt.face_size     = sh.size;
			nxt.face_vertex_a = 32'(ent.corners[sh.c0]);
			if (sh.size >= 3'd2) begin
				nxt.face_vertex_b = 32'(ent.corners[sh.c1]);
			end
			if (sh.size >= 3'd3) begin
				nxt.face_vertex_c = 32'(ent.corners[sh.c2]);
			end
			if (sh.size >= 3'd4) begin
				nxt.face_vertex_d = 32'(ent.corners[sh.c3]);
			end
		end
	end

	// face counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			k_q     <= 3'd0;
		end else if (advance) begin
			valid_q <= !empty;
			if (take) begin
				k_q <= last ? 3'd0 : k_q + 3'd1;
			end
		end
	end

	// output register and running offsets within the cell
	always_ff @(posedge clk) begin
		if (take) begin
			face_q <= nxt;
			pos_q  <= cur_pos + CW'(sh.size);
			ser_q  <= cur_ser + CW'(1);
		end
	end

	assign face       = face_q;
	assign face_valid = valid_q;

`ifndef ASSERT_OFF
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && face_q.bad_kind |-> face_q.last_face && face_q.face_size == 3'd0)
		else $error("error beat not a single empty face");
	a_good_size: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !face_q.bad_kind |-> face_q.face_size != 3'd0)
		else $error("face of a known cell has no corners");
	a_face_index: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= 3'd5) else $error("face index beyond six faces");
	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> k_q == 3'd0) else $error("face index left mid-cell with no cell");
`endif

endmodule

@@ rtl/cell_face_decomposer_core.sv @@
`timescale 1ns / 1ps

// Cell face decomposer. Each cell beat is split into its boundary faces,
// one face beat per clock unless stalled: one for a bar, triangle, quad,
// point or unknown type, four for a tetrahedron, five for a pyramid or
// prism, six for a hexahedron. The single face output register sets that
// rate. The front classifies a cell and assigns its running offsets in
// the cycle it is accepted, and keeps accepting a cell per clock while
// its two-entry queue to the face generator has room, so input and output
// stall independently. Each face carries its start offset in the running
// vertex list and its serial number; mesh_start clears both counters
// before its cell, and both wrap at COUNT_BITS. An unknown type gives one
// face beat with bad_kind set and leaves the counters unchanged.
module cell_face_decomposer_core import cfd_pkg::*; #(
	parameter int INDEX_BITS = 32,
	parameter int COUNT_BITS = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cell_t mesh_cell,
	input  logic  cell_valid,
	output logic  cell_stall,
	output face_t face,
	output logic  face_valid,
	input  logic  face_stall
);

	localparam int IW = (INDEX_BITS < 32) ? INDEX_BITS : 32;
	localparam int CW = COUNT_BITS;
	localparam int EW = 1 + 3 + 5 + 2 * CW + 8 * IW;

	logic          full;
	logic          push;
	logic          pop;
	logic          empty;
	logic [EW-1:0] wdata;
	logic [EW-1:0] rdata;

	cfd_front #(.IW(IW), .CW(CW), .EW(EW)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mesh_cell  (mesh_cell),
		.cell_valid (cell_valid),
		.cell_stall (cell_stall),
		.full       (full),
		.push       (push),
		.entry      (wdata)
	);

	cfd_queue #(.WIDTH(EW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wdata),
		.full   (full),
		.pop    (pop),
		.rdata  (rdata),
		.empty  (empty)
	);

	cfd_back #(.IW(IW), .CW(CW), .EW(EW)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.entry      (rdata),
		.empty      (empty),
		.pop        (pop),
		.face       (face),
		.face_valid (face_valid),
		.face_stall (face_stall)
	);

endmodule
